>>> src/servo_pulse_ramp_profile_core_macros.svh
// Assertion macros shared by the checker of the servo pulse ramp core.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SERVO_PULSE_RAMP_PROFILE_CORE_MACROS_SVH
`define SERVO_PULSE_RAMP_PROFILE_CORE_MACROS_SVH

// Clocked check, off while reset is asserted
`define SPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define SPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/spr_pkg.sv
// Shared types and constants for the servo pulse ramp core.
// No dependencies; imported by every module of the block except the divider.
package spr_pkg;

    // Field widths
    localparam int STEP_W  = 14;
    localparam int PULSE_W = 14;
    localparam int PROF_W  = 4;
    localparam int TICK_W  = 16;
    localparam int CMP_W   = 24;
    localparam int Q16_W   = 17;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register indexes (word address bits)
    localparam logic [2:0] REG_START   = 3'd0;
    localparam logic [2:0] REG_END     = 3'd1;
    localparam logic [2:0] REG_STEPS   = 3'd2;
    localparam logic [2:0] REG_PROFILE = 3'd3;
    localparam logic [2:0] REG_TICK    = 3'd4;

    // Register reset values
    localparam logic [PULSE_W-1:0] START_RST   = 14'd500;
    localparam logic [PULSE_W-1:0] END_RST     = 14'd2500;
    localparam logic [STEP_W-1:0]  STEPS_RST   = 14'd1000;
    localparam logic [PROF_W-1:0]  PROFILE_RST = 4'd0;
    localparam logic [TICK_W-1:0]  TICK_RST    = 16'd500;

    // Profile codes
    localparam logic [PROF_W-1:0] PROF_LINEAR     = 4'd0;
    localparam logic [PROF_W-1:0] PROF_SQUARE     = 4'd1;
    localparam logic [PROF_W-1:0] PROF_EASE_OUT   = 4'd2;
    localparam logic [PROF_W-1:0] PROF_SMOOTH     = 4'd3;
    localparam logic [PROF_W-1:0] PROF_IN_SINE    = 4'd4;
    localparam logic [PROF_W-1:0] PROF_OUT_SINE   = 4'd5;
    localparam logic [PROF_W-1:0] PROF_INOUT_SINE = 4'd6;
    localparam logic [PROF_W-1:0] PROF_STEP       = 4'd7;

    // Arithmetic constants
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
    localparam logic [9:0]        NS_PER_US   = 10'd1000;
    localparam logic [3:0]        STEP_TENTHS = 4'd10;
    localparam logic [CMP_W-1:0]  CMP_MAX     = 24'hFFFFFF;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [PULSE_W-1:0] start_pulse_us;
        logic [PULSE_W-1:0] end_pulse_us;
        logic [STEP_W-1:0]  ramp_steps;
        logic [PROF_W-1:0]  profile_select;
        logic [TICK_W-1:0]  tick_ns;
    } spr_cfg_t;

    // sin(a) for a in Q2.30, Taylor series to the x^17 term, elaboration only
    function automatic logic [63:0] sin_q30(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        a2   = (a * a) >> 30;
        term = a;
        sum  = $signed(a);
        term = ((term * a2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        return $unsigned(sum);
    endfunction

endpackage

>>> src/spr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; used twice by the servo pulse ramp core.
module spr_div_pipe #(
    parameter int DEN_W  = 14,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [DEN_W-1:0]  den,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_num,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [0:Q_W-1];
    logic [DEN_W-1:0]  rem_reg  [0:Q_W-1];
    logic [Q_W-1:0]    w_reg    [0:Q_W-1];
    logic [SIDE_W-1:0] side_reg [0:Q_W-1];

    logic              vld_src  [0:Q_W-1];
    logic [DEN_W-1:0]  rem_src  [0:Q_W-1];
    logic [Q_W-1:0]    w_src    [0:Q_W-1];
    logic [SIDE_W-1:0] side_src [0:Q_W-1];
    logic [DEN_W:0]    trial    [0:Q_W-1];
    logic [DEN_W:0]    diff     [0:Q_W-1];
    logic [DEN_W-1:0]  rem_next [0:Q_W-1];
    logic [Q_W-1:0]    w_next   [0:Q_W-1];

    // Stage sources: first stage from the inputs, others from the stage before
    always_comb
    begin
        vld_src[0]  = in_valid;
        rem_src[0]  = in_rem;
        w_src[0]    = in_num;
        side_src[0] = in_side;
        for (int s = 1; s < Q_W; s++)
        begin
            vld_src[s]  = vld_reg[s-1];
            rem_src[s]  = rem_reg[s-1];
            w_src[s]    = w_reg[s-1];
            side_src[s] = side_reg[s-1];
        end
    end

    // One trial subtract per stage; quotient bits shift in behind the dividend
    always_comb
    begin
        for (int s = 0; s < Q_W; s++)
        begin
            trial[s] = {rem_src[s], w_src[s][Q_W-1]};
            diff[s]  = trial[s] - {1'b0, den};
            if (trial[s] >= {1'b0, den})
            begin
                rem_next[s] = diff[s][DEN_W-1:0];
                w_next[s]   = {w_src[s][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = trial[s][DEN_W-1:0];
                w_next[s]   = {w_src[s][Q_W-2:0], 1'b0};
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                vld_reg[s] <= vld_src[s];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                w_reg[s]    <= w_next[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = w_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

>>> src/spr_shaper.sv
// Four-stage profile shaper: polynomial curves and quarter-wave sine lookup.
// Depends on spr_pkg (profile codes, sine series function).
module spr_shaper import spr_pkg::*; #(
    parameter int FRAC_BITS        = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [PROF_W-1:0] profile,
    input  logic              in_valid,
    input  logic [FRAC_BITS-1:0] x_frac,
    input  logic              in_full,
    input  logic              in_step,
    output logic              out_valid,
    output logic [FRAC_BITS:0] shaped
);

    localparam int F  = FRAC_BITS;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = F + IW;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic [63:0]   RND       = 64'd1 << (SH - 1);
    localparam logic [F:0]    ONE       = {1'b1, {F{1'b0}}};
    localparam logic [F+1:0]  TWO_ONE   = {2'b10, {F{1'b0}}};
    localparam logic [F+2:0]  THREE_ONE = {3'b011, {F{1'b0}}};
    localparam logic [IW-1:0] DEPTH_IDX = IW'(SINE_TABLE_DEPTH);

    // Quarter-wave sine table, rounded to Q1.F
    wire [F:0] sine_tab [0:SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++)
    begin : g_tab
        localparam logic [63:0] ANG = (HALF_PI_Q30 * 64'(gi)) / SINE_TABLE_DEPTH;
        localparam logic [63:0] RAW = (sin_q30(ANG) + RND) >> SH;
        assign sine_tab[gi] = (RAW > 64'(ONE)) ? ONE : RAW[F:0];
    end

    // Stage A: progress, table address and fraction
    logic [F:0]    x_a;
    logic [F:0]    u_a;
    logic [PW-1:0] p_a;
    logic          a_valid_reg;
    logic [F:0]    a_x_reg;
    logic [IW-1:0] a_tidx_reg;
    logic [F-1:0]  a_fr_reg;
    logic          a_sat_reg;
    logic          a_step_reg;

    always_comb
    begin
        x_a = in_full ? ONE : {1'b0, x_frac};
        u_a = (profile == PROF_IN_SINE) ? (ONE - x_a) : x_a;
        p_a = PW'(u_a) * PW'(SINE_TABLE_DEPTH);
    end

    // Stage B: table read, square and ease-out product
    logic [F:0]     t0_b;
    logic [F:0]     t1_b;
    logic [IW-1:0]  t1_idx_b;
    logic [2*F+1:0] sq_b;
    logic [F+1:0]   mid_b;
    logic [2*F+2:0] p2_b;
    logic           b_valid_reg;
    logic [F:0]     b_x_reg;
    logic [F:0]     b_t0_reg;
    logic [F:0]     b_dt_reg;
    logic [F-1:0]   b_fr_reg;
    logic [F:0]     b_xx_reg;
    logic [F:0]     b_p2_reg;
    logic           b_step_reg;

    always_comb
    begin
        t1_idx_b = a_sat_reg ? a_tidx_reg : (a_tidx_reg + IW'(1));
        t0_b     = sine_tab[a_tidx_reg];
        t1_b     = sine_tab[t1_idx_b];
        sq_b     = a_x_reg * a_x_reg;
        mid_b    = TWO_ONE - {1'b0, a_x_reg};
        p2_b     = a_x_reg * mid_b;
    end

    // Stage C: sine interpolation and smoothstep product
    logic [2*F:0]   interp_c;
    logic [F:0]     sv_c;
    logic [F+2:0]   k3_c;
    logic [2*F+3:0] r3p_c;
    logic [F+3:0]   r3_c;
    logic           c_valid_reg;
    logic [F:0]     c_x_reg;
    logic [F:0]     c_sv_reg;
    logic [F:0]     c_xx_reg;
    logic [F:0]     c_p2_reg;
    logic [F:0]     c_r3_reg;
    logic           c_step_reg;

    always_comb
    begin
        interp_c = b_dt_reg * b_fr_reg;
        sv_c     = b_t0_reg + interp_c[2*F:F];
        k3_c     = THREE_ONE - {1'b0, b_x_reg, 1'b0};
        r3p_c    = b_xx_reg * k3_c;
        r3_c     = r3p_c[2*F+3:F];
    end

    // Stage D: sine squared and curve select
    logic [2*F+1:0] s2p_d;
    logic [F:0]     sel_d;
    logic           d_valid_reg;
    logic [F:0]     d_s_reg;

    always_comb
    begin
        s2p_d = c_sv_reg * c_sv_reg;
        case (profile)
            PROF_SQUARE:     sel_d = c_xx_reg;
            PROF_EASE_OUT:   sel_d = c_p2_reg;
            PROF_SMOOTH:     sel_d = c_r3_reg;
            PROF_IN_SINE:    sel_d = ONE - c_sv_reg;
            PROF_OUT_SINE:   sel_d = c_sv_reg;
            PROF_INOUT_SINE: sel_d = s2p_d[2*F:F];
            PROF_STEP:       sel_d = c_step_reg ? ONE : '0;
            default:         sel_d = c_x_reg;
        endcase
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg    <= x_a;
            a_tidx_reg <= p_a[PW-1:F];
            a_fr_reg   <= p_a[F-1:0];
            a_sat_reg  <= (p_a[PW-1:F] >= DEPTH_IDX);
            a_step_reg <= in_full | in_step;

            b_x_reg    <= a_x_reg;
            b_t0_reg   <= t0_b;
            b_dt_reg   <= (t1_b > t0_b) ? (t1_b - t0_b) : '0;
            b_fr_reg   <= a_fr_reg;
            b_xx_reg   <= sq_b[2*F:F];
            b_p2_reg   <= p2_b[2*F:F];
            b_step_reg <= a_step_reg;

            c_x_reg    <= b_x_reg;
            c_sv_reg   <= sv_c;
            c_xx_reg   <= b_xx_reg;
            c_p2_reg   <= b_p2_reg;
            c_r3_reg   <= (r3_c > (F+4)'(ONE)) ? ONE : r3_c[F:0];
            c_step_reg <= b_step_reg;

            d_s_reg    <= sel_d;
        end
    end

    assign out_valid = d_valid_reg;
    assign shaped    = d_s_reg;

endmodule

>>> src/spr_pulse_calc.sv
// Two-stage pulse width interpolation between start and end widths.
// Depends on spr_pkg (field widths).
module spr_pulse_calc import spr_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [PULSE_W-1:0] start_pulse_us,
    input  logic [PULSE_W-1:0] end_pulse_us,
    input  logic               in_valid,
    input  logic [FRAC_BITS:0] in_shaped,
    output logic               out_valid,
    output logic [PULSE_W-1:0] out_pulse,
    output logic [FRAC_BITS:0] out_shaped
);

    localparam int F  = FRAC_BITS;
    localparam int MW = F + 1 + PULSE_W;

    // Stage E: span magnitude times shaped progress
    logic               fall_e;
    logic [PULSE_W-1:0] mag_e;
    logic               e_valid_reg;
    logic [MW-1:0]      e_prod_reg;
    logic               e_fall_reg;
    logic [F:0]         e_s_reg;

    always_comb
    begin
        fall_e = end_pulse_us < start_pulse_us;
        mag_e  = fall_e ? (start_pulse_us - end_pulse_us) : (end_pulse_us - start_pulse_us);
    end

    // Stage F: truncate for a rising ramp, round the offset up for a falling one
    logic [MW:0]        ceil_f;
    logic [PULSE_W-1:0] pulse_f;
    logic               f_valid_reg;
    logic [PULSE_W-1:0] f_pulse_reg;
    logic [F:0]         f_s_reg;

    always_comb
    begin
        ceil_f = {1'b0, e_prod_reg} + (MW+1)'({F{1'b1}});
        if (e_fall_reg)
        begin
            pulse_f = start_pulse_us - ceil_f[F+PULSE_W-1:F];
        end
        else
        begin
            pulse_f = start_pulse_us + e_prod_reg[F+PULSE_W-1:F];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_prod_reg  <= in_shaped * mag_e;
            e_fall_reg  <= fall_e;
            e_s_reg     <= in_shaped;
            f_pulse_reg <= pulse_f;
            f_s_reg     <= e_s_reg;
        end
    end

    assign out_valid  = f_valid_reg;
    assign out_pulse  = f_pulse_reg;
    assign out_shaped = f_s_reg;

endmodule

>>> src/servo_pulse_ramp_profile_core.sv
// Servo pulse ramp core: step index to shaped progress, pulse and compare.
// Fully pipelined: progress divider, shaper, pulse stage, compare divider.
// Channels: step_index comes in on in_valid/in_ready, one beat per item;
// progress_shaped, pulse_us and compare_value leave together on
// out_valid/out_ready, one beat per item, in order.
// Pipeline: FRAC_BITS + 30 register stages (FRAC_BITS progress divider, four
// shaper, two pulse, 24 compare divider).
// Throughput: one item per cycle; a new beat is taken every cycle while
// the output is empty or being taken.
// Stall: when out_valid is high and out_ready low the whole pipeline holds,
// in_ready drops, and nothing is lost or repeated.
// Reset: rst_n clears all valid bits and loads the register defaults
// (start 500, end 2500, steps 1000, linear profile, tick 500 ns); the sine
// table is constant, so no warm-up is needed.
// Registers (APB, 32-bit data, word aligned): 0x00 start_pulse_us,
// 0x04 end_pulse_us, 0x08 ramp_steps, 0x0C profile_select, 0x10 tick_ns.
// Write registers only while the pipeline is empty.
module servo_pulse_ramp_profile_core import spr_pkg::*; #(
    parameter int FRAC_BITS        = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [STEP_W-1:0]  step_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [Q16_W-1:0]   progress_shaped,
    output logic [PULSE_W-1:0] pulse_us,
    output logic [CMP_W-1:0]   compare_value
);

    localparam int F      = FRAC_BITS;
    localparam int SIDE_W = Q16_W + PULSE_W;

    // Configuration registers
    spr_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_pulse_us <= START_RST;
            cfg_reg.end_pulse_us   <= END_RST;
            cfg_reg.ramp_steps     <= STEPS_RST;
            cfg_reg.profile_select <= PROFILE_RST;
            cfg_reg.tick_ns        <= TICK_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START:   cfg_reg.start_pulse_us <= pwdata[PULSE_W-1:0];
                REG_END:     cfg_reg.end_pulse_us   <= pwdata[PULSE_W-1:0];
                REG_STEPS:   cfg_reg.ramp_steps     <= pwdata[STEP_W-1:0];
                REG_PROFILE: cfg_reg.profile_select <= pwdata[PROF_W-1:0];
                REG_TICK:    cfg_reg.tick_ns        <= pwdata[TICK_W-1:0];
                default:     ;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        case (reg_idx)
            REG_START:   prdata = DATA_W'(cfg_reg.start_pulse_us);
            REG_END:     prdata = DATA_W'(cfg_reg.end_pulse_us);
            REG_STEPS:   prdata = DATA_W'(cfg_reg.ramp_steps);
            REG_PROFILE: prdata = DATA_W'(cfg_reg.profile_select);
            REG_TICK:    prdata = DATA_W'(cfg_reg.tick_ns);
            default:     prdata = '0;
        endcase
    end

    // Pipeline advances unless a finished beat is waiting
    logic adv;
    assign adv      = ~out_valid | out_ready;
    assign in_ready = adv;

    // Front end: clamp check and the one-tenth threshold for the step profile
    logic              full_in;
    logic              gt_tenth_in;
    logic [STEP_W-1:0] rem0_in;

    always_comb
    begin
        full_in     = (cfg_reg.ramp_steps == '0) || (step_index >= cfg_reg.ramp_steps);
        gt_tenth_in = ((STEP_W+4)'(step_index) * (STEP_W+4)'(STEP_TENTHS))
                      > (STEP_W+4)'(cfg_reg.ramp_steps);
        rem0_in     = full_in ? '0 : step_index;
    end

    // Progress divider: x = index * 2^F / steps
    logic         x_valid;
    logic [F-1:0] x_frac;
    logic [1:0]   x_side;

    spr_div_pipe #(
        .DEN_W  (STEP_W),
        .Q_W    (F),
        .SIDE_W (2)
    ) u_xdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .den       (cfg_reg.ramp_steps),
        .in_valid  (in_valid & in_ready),
        .in_rem    (rem0_in),
        .in_num    ('0),
        .in_side   ({full_in, gt_tenth_in}),
        .out_valid (x_valid),
        .out_quo   (x_frac),
        .out_side  (x_side)
    );

    // Curve shaping
    logic       sh_valid;
    logic [F:0] shaped;

    spr_shaper #(
        .FRAC_BITS        (FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_shaper (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .profile   (cfg_reg.profile_select),
        .in_valid  (x_valid),
        .x_frac    (x_frac),
        .in_full   (x_side[1]),
        .in_step   (x_side[0]),
        .out_valid (sh_valid),
        .shaped    (shaped)
    );

    // Pulse width
    logic               pw_valid;
    logic [PULSE_W-1:0] pw_pulse;
    logic [F:0]         pw_shaped;

    spr_pulse_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pulse (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .start_pulse_us (cfg_reg.start_pulse_us),
        .end_pulse_us   (cfg_reg.end_pulse_us),
        .in_valid       (sh_valid),
        .in_shaped      (shaped),
        .out_valid      (pw_valid),
        .out_pulse      (pw_pulse),
        .out_shaped     (pw_shaped)
    );

    // Shaped progress in Q1.16
    logic [Q16_W-1:0] q16;

    if (F >= 16)
    begin : g_q16_down
        assign q16 = pw_shaped[F:F-16];
    end
    else
    begin : g_q16_up
        assign q16 = {pw_shaped, {(16-F){1'b0}}};
    end

    // Compare divider: pulse * 1000 / tick_ns
    logic [CMP_W-1:0]  cmp_num;
    logic [CMP_W-1:0]  cmp_quo;
    logic [SIDE_W-1:0] cmp_side;

    assign cmp_num = CMP_W'(pw_pulse) * CMP_W'(NS_PER_US);

    spr_div_pipe #(
        .DEN_W  (TICK_W),
        .Q_W    (CMP_W),
        .SIDE_W (SIDE_W)
    ) u_cdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .den       (cfg_reg.tick_ns),
        .in_valid  (pw_valid),
        .in_rem    ('0),
        .in_num    (cmp_num),
        .in_side   ({q16, pw_pulse}),
        .out_valid (out_valid),
        .out_quo   (cmp_quo),
        .out_side  (cmp_side)
    );

    // Output beat
    assign progress_shaped = cmp_side[SIDE_W-1:PULSE_W];
    assign pulse_us        = cmp_side[PULSE_W-1:0];
    assign compare_value   = (cfg_reg.tick_ns == '0) ? CMP_MAX : cmp_quo;

endmodule

>>> src/spr_checker.sv
// Port-level checker for the servo pulse ramp core, bound to the top level.
// Depends on spr_pkg and servo_pulse_ramp_profile_core_macros.svh.
`include "servo_pulse_ramp_profile_core_macros.svh"

module spr_checker import spr_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               pready,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [Q16_W-1:0]   progress_shaped,
    input logic [PULSE_W-1:0] pulse_us,
    input logic [CMP_W-1:0]   compare_value
);

    // A waiting output beat blocks new input
    `SPR_ASSERT(a_stall_blocks_in, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")

    // Empty output always takes input
    `SPR_ASSERT(a_empty_takes_in, !out_valid |-> in_ready, "input refused with empty output")

    // Stalled beat holds
    `SPR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pulse_us) && $stable(compare_value) && $stable(progress_shaped), "stalled output beat changed")

    // Reset empties the output and leaves the bus ready
    `SPR_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid && pready, "output valid during reset")

endmodule

bind servo_pulse_ramp_profile_core spr_checker u_spr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pready          (pready),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .progress_shaped (progress_shaped),
    .pulse_us        (pulse_us),
    .compare_value   (compare_value)
);
